// ===== rtl/bti_pkg.sv =====
// shared types, constants and codes for the bilinear table interpolator
`timescale 1ns / 1ps
`default_nettype none
package bti_pkg;

  localparam int DEF_MAX_X = 32;
  localparam int DEF_MAX_Y = 32;

  // control counter, wide enough for the largest breakpoint count and the divider
  localparam int CNT_W = 9;
  // numerator magnitude of the four-corner sum
  localparam int NUM_W = 98;
  localparam int DEN_W = 64;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_X_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_COUNT = 1'd1;
  localparam logic [CFG_W-1:0] COUNT_RESET = 6'd2;

  localparam logic [CNT_W-1:0] TERM_LAST = 9'd15;
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NUM_W - 1);

  typedef enum logic [1:0] {
    MODE_WR_X    = 2'd0,
    MODE_WR_Y    = 2'd1,
    MODE_WR_GRID = 2'd2,
    MODE_QUERY   = 2'd3
  } mode_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLAMP_LO,
    S_CLAMP_HI,
    S_CLAMP_DO,
    S_SEARCH,
    S_DRAIN,
    S_ZCHECK,
    S_TERM,
    S_DEN,
    S_DIV_INIT,
    S_DIV,
    S_SAT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic             load_q;
    logic             rd_lo;
    logic             rd_hi;
    logic             clamp_lo;
    logic             clamp_hi;
    logic             srch_rd;
    logic             zchk;
    logic             term;
    logic             den_mul;
    logic             div_init;
    logic             div_step;
    logic             sat;
    logic             zero_out;
    logic             out_load;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic srch_last;
    logic zero_w;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/bti_if.sv =====
// item channels of the bilinear table interpolator
`timescale 1ns / 1ps
`default_nettype none
interface bti_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [4:0]         row_index;
  logic [4:0]         col_index;
  logic signed [31:0] write_value;
  logic signed [31:0] query_x;
  logic signed [31:0] query_y;

  modport source(output valid, mode, row_index, col_index, write_value, query_x, query_y,
                 input ready);
  modport sink(input valid, mode, row_index, col_index, write_value, query_x, query_y,
               output ready);
endinterface

interface bti_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] interp_value;
  logic [1:0]         status;

  modport source(output valid, interp_value, status, input ready);
  modport sink(input valid, interp_value, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/bti_ram.sv =====
// single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module bti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bti_ctrl.sv =====
// query sequencer of the bilinear table interpolator
`timescale 1ns / 1ps
`default_nettype none
module bti_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_fire,
  input  wire logic           in_query,
  input  wire bti_pkg::sts_t  sts,
  output bti_pkg::cmd_t       cmd,
  output logic                in_ready
);
  import bti_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.cnt    = cnt;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire && in_query) begin
          cmd.load_q = 1'b1;
          state_next = S_CLAMP_LO;
        end
      end
      S_CLAMP_LO: begin
        cmd.rd_lo  = 1'b1;
        state_next = S_CLAMP_HI;
      end
      S_CLAMP_HI: begin
        cmd.rd_hi    = 1'b1;
        cmd.clamp_lo = 1'b1;
        state_next   = S_CLAMP_DO;
      end
      S_CLAMP_DO: begin
        cmd.clamp_hi = 1'b1;
        cnt_next     = '0;
        state_next   = S_SEARCH;
      end
      S_SEARCH: begin
        cmd.srch_rd = 1'b1;
        cnt_next    = cnt + CNT_W'(1);
        if (sts.srch_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_ZCHECK;
      end
      S_ZCHECK: begin
        cnt_next = '0;
        if (sts.zero_w) begin
          cmd.zero_out = 1'b1;
          state_next   = S_FINISH;
        end else begin
          cmd.zchk   = 1'b1;
          state_next = S_TERM;
        end
      end
      S_TERM: begin
        cmd.term = 1'b1;
        cnt_next = cnt + CNT_W'(1);
        if (cnt == TERM_LAST) begin
          state_next = S_DEN;
        end
      end
      S_DEN: begin
        cmd.den_mul = 1'b1;
        state_next  = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + CNT_W'(1);
        if (cnt == DIV_LAST) begin
          state_next = S_SAT;
        end
      end
      S_SAT: begin
        cmd.sat    = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/bti_dp.sv =====
// table storage, search, multiply-accumulate and divider of the interpolator
`timescale 1ns / 1ps
`default_nettype none
module bti_dp #(
  parameter int MAX_X_POINTS = bti_pkg::DEF_MAX_X,
  parameter int MAX_Y_POINTS = bti_pkg::DEF_MAX_Y
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire bti_pkg::cmd_t                 cmd,
  output bti_pkg::sts_t                      sts,
  input  wire logic                          in_fire,
  input  wire logic [1:0]                    mode,
  input  wire logic [4:0]                    row_index,
  input  wire logic [4:0]                    col_index,
  input  wire logic signed [31:0]            write_value,
  input  wire logic signed [31:0]            query_x,
  input  wire logic signed [31:0]            query_y,
  input  wire logic                          cfg_we,
  input  wire logic [bti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bti_pkg::CFG_W-1:0]     cfg_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [31:0]                 interp_value,
  output logic [1:0]                         status
);
  import bti_pkg::*;

  localparam int XAW = $clog2(MAX_X_POINTS);
  localparam int YAW = $clog2(MAX_Y_POINTS);
  localparam int GD  = MAX_X_POINTS * MAX_Y_POINTS;
  localparam int GAW = $clog2(GD);

  function automatic logic [32:0] sdiff(logic signed [31:0] a, logic signed [31:0] b);
    return {a[31], a} - {b[31], b};
  endfunction

  function automatic logic [31:0] mag33(logic [32:0] v);
    logic [32:0] n;
    n = ~v + 33'd1;
    return v[32] ? n[31:0] : v[31:0];
  endfunction

  // configuration
  logic [CFG_W-1:0] x_count, y_count;
  logic [CNT_W-1:0] nx, ny, nmax;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_count <= COUNT_RESET;
      y_count <= COUNT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_X_COUNT) begin
        x_count <= cfg_data;
      end
      if (cfg_index == CFG_Y_COUNT) begin
        y_count <= cfg_data;
      end
    end
  end

  always_comb begin
    if (x_count < CFG_W'(2)) begin
      nx = CNT_W'(2);
    end else if (CNT_W'(x_count) > CNT_W'(MAX_X_POINTS)) begin
      nx = CNT_W'(MAX_X_POINTS);
    end else begin
      nx = CNT_W'(x_count);
    end
    if (y_count < CFG_W'(2)) begin
      ny = CNT_W'(2);
    end else if (CNT_W'(y_count) > CNT_W'(MAX_Y_POINTS)) begin
      ny = CNT_W'(MAX_Y_POINTS);
    end else begin
      ny = CNT_W'(y_count);
    end
    nmax = (nx > ny) ? nx : ny;
  end

  // memories
  logic           x_we, y_we, g_we, x_re, y_re, g_re;
  logic [XAW-1:0] x_addr;
  logic [YAW-1:0] y_addr;
  logic [GAW-1:0] g_addr, g_rd_addr;
  logic [31:0]    x_rdata, y_rdata, g_rdata;
  logic [1:0]     tsel, ph;
  logic [XAW-1:0] xi;
  logic [YAW-1:0] yi;

  assign tsel = cmd.cnt[3:2];
  assign ph   = cmd.cnt[1:0];

  always_comb begin
    x_we = in_fire && (mode_t'(mode) == MODE_WR_X) && (32'(row_index) < MAX_X_POINTS);
    y_we = in_fire && (mode_t'(mode) == MODE_WR_Y) && (32'(col_index) < MAX_Y_POINTS);
    g_we = in_fire && (mode_t'(mode) == MODE_WR_GRID) &&
           (32'(row_index) < MAX_X_POINTS) && (32'(col_index) < MAX_Y_POINTS);
    x_re = cmd.rd_lo || cmd.rd_hi || cmd.srch_rd;
    y_re = x_re;
    g_re = cmd.term && (ph == 2'd0);
    g_rd_addr = GAW'((32'(xi) + 32'(tsel[0])) * MAX_Y_POINTS + 32'(yi) + 32'(tsel[1]));
    if (x_we) begin
      x_addr = XAW'(row_index);
    end else if (cmd.rd_lo) begin
      x_addr = '0;
    end else if (cmd.rd_hi) begin
      x_addr = XAW'(nx - CNT_W'(1));
    end else begin
      x_addr = cmd.cnt[XAW-1:0];
    end
    if (y_we) begin
      y_addr = YAW'(col_index);
    end else if (cmd.rd_lo) begin
      y_addr = '0;
    end else if (cmd.rd_hi) begin
      y_addr = YAW'(ny - CNT_W'(1));
    end else begin
      y_addr = cmd.cnt[YAW-1:0];
    end
    if (g_we) begin
      g_addr = GAW'(32'(row_index) * MAX_Y_POINTS + 32'(col_index));
    end else begin
      g_addr = g_rd_addr;
    end
  end

  bti_ram #(.WIDTH(32), .DEPTH(MAX_X_POINTS)) u_x_ram (
    .clk(clk), .we(x_we), .re(x_re), .addr(x_addr), .wdata(write_value), .rdata(x_rdata)
  );

  bti_ram #(.WIDTH(32), .DEPTH(MAX_Y_POINTS)) u_y_ram (
    .clk(clk), .we(y_we), .re(y_re), .addr(y_addr), .wdata(write_value), .rdata(y_rdata)
  );

  bti_ram #(.WIDTH(32), .DEPTH(GD)) u_g_ram (
    .clk(clk), .we(g_we), .re(g_re), .addr(g_addr), .wdata(write_value), .rdata(g_rdata)
  );

  // clamp and interval search
  logic signed [31:0] qx, qy, xd, yd;
  logic signed [31:0] xprev, x1, x2, yprev, y1, y2;
  logic               xfound, yfound, srch_v;
  logic [CNT_W-1:0]   srch_k, srch_km1;

  assign xd       = x_rdata;
  assign yd       = y_rdata;
  assign srch_km1 = srch_k - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      srch_v <= 1'b0;
    end else begin
      srch_v <= cmd.srch_rd;
    end
    srch_k <= cmd.cnt;
    if (cmd.load_q) begin
      qx <= query_x;
      qy <= query_y;
    end
    if (cmd.clamp_lo) begin
      if (qx < xd) qx <= xd;
      if (qy < yd) qy <= yd;
    end
    if (cmd.clamp_hi) begin
      if (qx > xd) qx <= xd;
      if (qy > yd) qy <= yd;
    end
    if (srch_v && (srch_k < nx)) begin
      xprev <= xd;
      if (srch_k == '0) begin
        xfound <= 1'b0;
      end else if (!xfound) begin
        x1     <= xprev;
        x2     <= xd;
        xi     <= srch_km1[XAW-1:0];
        xfound <= (qx >= xprev) && (qx <= xd);
      end
    end
    if (srch_v && (srch_k < ny)) begin
      yprev <= yd;
      if (srch_k == '0) begin
        yfound <= 1'b0;
      end else if (!yfound) begin
        y1     <= yprev;
        y2     <= yd;
        yi     <= srch_km1[YAW-1:0];
        yfound <= (qy >= yprev) && (qy <= yd);
      end
    end
  end

  // corner weights and shared 32x32 multiplier
  logic [31:0]              da0, da1, db0, db1, mdx, mdy, zmag, mul_a, mul_b;
  logic                     sa0, sa1, sb0, sb1, dneg, tneg;
  logic [63:0]              prod, pkeep;
  logic signed [NUM_W-1:0]  acc;
  logic [32:0]              dx, dy, ex2q, eqx1, ey2q, eqy1;

  assign dx   = sdiff(x2, x1);
  assign dy   = sdiff(y2, y1);
  assign ex2q = sdiff(x2, qx);
  assign eqx1 = sdiff(qx, x1);
  assign ey2q = sdiff(y2, qy);
  assign eqy1 = sdiff(qy, y1);
  assign zmag = mag33({g_rdata[31], g_rdata});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.den_mul) begin
      mul_a = mdx;
      mul_b = mdy;
    end else begin
      case (ph)
        2'd0: begin
          mul_a = tsel[0] ? da1 : da0;
          mul_b = tsel[1] ? db1 : db0;
        end
        2'd1: begin
          mul_a = prod[31:0];
          mul_b = zmag;
        end
        2'd2: begin
          mul_a = pkeep[63:32];
          mul_b = zmag;
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.zchk) begin
      da0  <= mag33(ex2q);
      sa0  <= ex2q[32];
      da1  <= mag33(eqx1);
      sa1  <= eqx1[32];
      db0  <= mag33(ey2q);
      sb0  <= ey2q[32];
      db1  <= mag33(eqy1);
      sb1  <= eqy1[32];
      mdx  <= mag33(dx);
      mdy  <= mag33(dy);
      dneg <= dx[32] ^ dy[32];
      acc  <= '0;
    end
    if (cmd.term || cmd.den_mul) begin
      prod <= 64'(mul_a) * 64'(mul_b);
    end
    if (cmd.term) begin
      case (ph)
        2'd1: begin
          pkeep <= prod;
          tneg  <= g_rdata[31] ^ (tsel[0] ? sa1 : sa0) ^ (tsel[1] ? sb1 : sb0);
        end
        2'd2: begin
          acc <= tneg ? acc - NUM_W'(prod) : acc + NUM_W'(prod);
        end
        2'd3: begin
          acc <= tneg ? acc - NUM_W'({prod, 32'd0}) : acc + NUM_W'({prod, 32'd0});
        end
        default: begin
        end
      endcase
    end
  end

  // restoring division, one quotient bit per cycle
  logic [DEN_W-1:0] den, rem;
  logic [NUM_W-1:0] nmag, quo, lim;
  logic [DEN_W:0]   rem_sh, rem_sub;
  logic             qneg, ge;
  logic signed [31:0] res;
  logic [1:0]       res_st;

  assign rem_sh  = {rem, nmag[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den};
  assign ge      = rem_sh >= {1'b0, den};
  assign lim     = qneg ? NUM_W'(33'h0_8000_0000) : NUM_W'(33'h0_7fff_ffff);

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      den  <= prod;
      nmag <= acc[NUM_W-1] ? NUM_W'(-acc) : NUM_W'(acc);
      qneg <= acc[NUM_W-1] ^ dneg;
      rem  <= '0;
      quo  <= '0;
    end
    if (cmd.div_step) begin
      nmag <= nmag << 1;
      rem  <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo  <= {quo[NUM_W-2:0], ge};
    end
    if (cmd.zero_out) begin
      res    <= '0;
      res_st <= ST_ZERO;
    end
    if (cmd.sat) begin
      if (quo > lim) begin
        res    <= qneg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        res_st <= ST_SAT;
      end else begin
        res    <= qneg ? -quo[31:0] : quo[31:0];
        res_st <= ST_OK;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      interp_value <= res;
      status       <= res_st;
    end
  end

  assign sts.srch_last = (cmd.cnt == nmax - CNT_W'(1));
  assign sts.zero_w    = (x2 == x1) || (y2 == y1);
  assign sts.out_free  = !out_valid || out_ready;

endmodule
`default_nettype wire

// ===== rtl/bilinear_table_interp.sv =====
// top level of the bilinear lookup table interpolator
//
//  channel   dir   payload                                             result
//  in_item   in    mode, row_index, col_index, write_value, query_x/y  writes: none
//  out_item  out   interp_value, status                                one per query
//  cfg       in    cfg_we, cfg_index, cfg_data (x_count, y_count)      none
//
// a table write lands in the table when it is accepted; a query clamps the point,
// runs the breakpoint search over the larger effective breakpoint count
// (one memory read per cycle), sums the corner terms on the shared 32x32 multiplier
// and divides in the one-bit-per-cycle divider, or gives zero when an interval has zero width
// synchronous reset sets both counts to 2; table contents are undefined until written
// a finished result waits in the output register; a query stalls only at its end
`timescale 1ns / 1ps
`default_nettype none
module bilinear_table_interp #(
  parameter int MAX_X_POINTS = bti_pkg::DEF_MAX_X,
  parameter int MAX_Y_POINTS = bti_pkg::DEF_MAX_Y
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [bti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bti_pkg::CFG_W-1:0]     cfg_data,
  bti_in_if.sink                             in_item,
  bti_out_if.source                          out_item
);
  import bti_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_fire, in_query;

  assign in_fire  = in_item.valid && in_item.ready;
  assign in_query = (mode_t'(in_item.mode) == MODE_QUERY);

  bti_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_fire(in_fire),
    .in_query(in_query),
    .sts(sts),
    .cmd(cmd),
    .in_ready(in_item.ready)
  );

  bti_dp #(
    .MAX_X_POINTS(MAX_X_POINTS),
    .MAX_Y_POINTS(MAX_Y_POINTS)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .sts(sts),
    .in_fire(in_fire),
    .mode(in_item.mode),
    .row_index(in_item.row_index),
    .col_index(in_item.col_index),
    .write_value(in_item.write_value),
    .query_x(in_item.query_x),
    .query_y(in_item.query_y),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_item.valid),
    .out_ready(out_item.ready),
    .interp_value(out_item.interp_value),
    .status(out_item.status)
  );

endmodule
`default_nettype wire
